[sv/multi_cpu_set_assoc_tlb_lru_unit_assert.svh]
// Assertion macros for the TLB unit.
`ifndef MULTI_CPU_SET_ASSOC_TLB_LRU_UNIT_ASSERT_SVH
`define MULTI_CPU_SET_ASSOC_TLB_LRU_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checked outside of reset
`define MTLB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mtlb assertion failed");

// Checked at every edge, reset included
`define MTLB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mtlb assertion failed");

`else

`define MTLB_ASSERT(label, clk, rst, prop)
`define MTLB_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[sv/mtlb_pkg.sv]
package mtlb_pkg;

  // Geometry, and the field widths derived from it
  localparam int NUM_SETS = 512;
  localparam int NUM_WAYS = 4;
  localparam int SET_BITS = $clog2(NUM_SETS);
  localparam int WAY_W    = $clog2(NUM_WAYS);
  localparam int AGE_W    = WAY_W;
  localparam int PAGE_W   = 52;
  localparam int TAG_W    = PAGE_W - SET_BITS;
  localparam int CPU_IN_W = 2;
  localparam int CNT_W    = 3;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_INVAL  = 1'b1
  } mode_t;

  // One way of a set; a RAM row holds all ways of one CPU's set
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } way_t;

  typedef way_t [NUM_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic upd;
    logic clr_wr;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic skip;
    logic inval;
    logic idx_last;
  } sts_t;

endpackage

[sv/mtlb_if.sv]
interface mtlb_req_if;
  logic                             valid;
  logic                             ready;
  mtlb_pkg::mode_t                  mode;
  logic [mtlb_pkg::CPU_IN_W-1:0]    cpu;
  logic [mtlb_pkg::PAGE_W-1:0]      page;

  modport source (output valid, mode, cpu, page, input ready);
  modport sink (input valid, mode, cpu, page, output ready);
endinterface

interface mtlb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [mtlb_pkg::CNT_W-1:0]    cleared;

  modport source (output valid, hit, cleared, input ready);
  modport sink (input valid, hit, cleared, output ready);
endinterface

[sv/mtlb_ram.sv]
module mtlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/mtlb_ctrl.sv]
module mtlb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  mtlb_pkg::sts_t sts,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mtlb_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  // Sequencing: clear sweep, then read / update per row touched
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (sts.skip) begin
          state_next = ST_FINISH;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.upd = 1'b1;
        if (sts.inval && !sts.idx_last) state_next = ST_READ;
        else state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Output beat held until taken
  assign rsp_valid_next = cmd.out_load | (rsp_valid & ~rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

[sv/mtlb_dp.sv]
module mtlb_dp #(
  parameter int NUM_CPUS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mtlb_pkg::cmd_t                  cmd,
  output mtlb_pkg::sts_t                  sts,
  input  mtlb_pkg::mode_t                 mode,
  input  logic [mtlb_pkg::CPU_IN_W-1:0]   cpu,
  input  logic [mtlb_pkg::PAGE_W-1:0]     page,
  output logic                            hit,
  output logic [mtlb_pkg::CNT_W-1:0]      cleared
);

  localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int ROW_AW = CPU_W + mtlb_pkg::SET_BITS;
  localparam int ROWS   = NUM_CPUS * mtlb_pkg::NUM_SETS;
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);
  localparam logic [CPU_W-1:0]  LAST_CPU = CPU_W'(NUM_CPUS - 1);

  // Lowest set bit of a way vector
  function automatic logic [mtlb_pkg::WAY_W-1:0] first_way(
    input logic [mtlb_pkg::NUM_WAYS-1:0] v
  );
    logic [mtlb_pkg::WAY_W-1:0] r;
    r = '0;
    for (int w = mtlb_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      if (v[w]) r = mtlb_pkg::WAY_W'(w);
    end
    return r;
  endfunction

  // Row after reset: all invalid, age of way w is w
  function automatic mtlb_pkg::row_t reset_row();
    mtlb_pkg::row_t r;
    for (int w = 0; w < mtlb_pkg::NUM_WAYS; w++) begin
      r[w].valid = 1'b0;
      r[w].tag   = '0;
      r[w].age   = mtlb_pkg::AGE_W'(w);
    end
    return r;
  endfunction

  mtlb_pkg::mode_t                  mode_r;
  logic [mtlb_pkg::SET_BITS-1:0]    set_r;
  logic [mtlb_pkg::TAG_W-1:0]       tag_r;
  logic [CPU_W-1:0]                 idx;
  logic                             skip_r;
  logic                             hit_r;
  logic [mtlb_pkg::CNT_W-1:0]       cnt;
  logic [ROW_AW-1:0]                clr_addr;

  logic [ROW_AW-1:0]                row_addr;
  logic [ROW_AW-1:0]                waddr;
  logic [mtlb_pkg::ROW_W-1:0]       rdata;
  logic [mtlb_pkg::ROW_W-1:0]       wdata;
  mtlb_pkg::row_t                   cur;
  mtlb_pkg::row_t                   row_new;

  logic [mtlb_pkg::NUM_WAYS-1:0]    hit_vec;
  logic [mtlb_pkg::NUM_WAYS-1:0]    inv_vec;
  logic [mtlb_pkg::NUM_WAYS-1:0]    lru_vec;
  logic                             hit_any;
  logic [mtlb_pkg::WAY_W-1:0]       hit_way;
  logic [mtlb_pkg::WAY_W-1:0]       victim;
  logic [mtlb_pkg::AGE_W-1:0]       vic_age;

  // Item registers, per-CPU walk and result accumulation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      set_r  <= page[mtlb_pkg::SET_BITS-1:0];
      tag_r  <= page[mtlb_pkg::PAGE_W-1:mtlb_pkg::SET_BITS];
      idx    <= (mode == mtlb_pkg::MODE_INVAL) ? '0 : CPU_W'(cpu);
      skip_r <= (mode == mtlb_pkg::MODE_LOOKUP) && (32'(cpu) >= 32'(NUM_CPUS));
      hit_r  <= 1'b0;
      cnt    <= '0;
    end else if (cmd.upd) begin
      idx <= idx + 1'b1;
      if (mode_r == mtlb_pkg::MODE_LOOKUP) begin
        hit_r <= hit_any;
      end else if (hit_any && cnt != mtlb_pkg::CNT_MAX) begin
        cnt <= cnt + 1'b1;
      end
    end
    if (cmd.out_load) begin
      hit     <= hit_r;
      cleared <= cnt;
    end
  end

  // Clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Tag store, one row per CPU and set
  assign row_addr = {idx, set_r};
  assign waddr    = cmd.clr_wr ? clr_addr : row_addr;
  assign wdata    = cmd.clr_wr ? reset_row() : row_new;
  assign cur      = rdata;

  mtlb_ram #(
    .WIDTH(mtlb_pkg::ROW_W),
    .DEPTH(1 << ROW_AW)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.upd | cmd.clr_wr),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd),
    .raddr(row_addr),
    .rdata(rdata)
  );

  // Set-wide compare
  always_comb begin
    for (int w = 0; w < mtlb_pkg::NUM_WAYS; w++) begin
      hit_vec[w] = cur[w].valid && (cur[w].tag == tag_r);
      inv_vec[w] = !cur[w].valid;
      lru_vec[w] = cur[w].age == mtlb_pkg::AGE_W'(mtlb_pkg::NUM_WAYS - 1);
    end
  end

  assign hit_any = |hit_vec;
  assign hit_way = first_way(hit_vec);
  assign victim  = hit_any ? hit_way :
                   (|inv_vec) ? first_way(inv_vec) : first_way(lru_vec);
  assign vic_age = cur[victim].age;

  // Updated row: touch / fill for lookup, clear for invalidate
  always_comb begin
    row_new = cur;
    if (mode_r == mtlb_pkg::MODE_LOOKUP) begin
      for (int w = 0; w < mtlb_pkg::NUM_WAYS; w++) begin
        if (cur[w].age < vic_age) row_new[w].age = cur[w].age + 1'b1;
      end
      row_new[victim].age = '0;
      if (!hit_any) begin
        row_new[victim].valid = 1'b1;
        row_new[victim].tag   = tag_r;
      end
    end else if (hit_any) begin
      row_new[hit_way].valid = 1'b0;
    end
  end

  assign sts.clr_last = clr_addr == LAST_ROW;
  assign sts.skip     = skip_r;
  assign sts.inval    = mode_r == mtlb_pkg::MODE_INVAL;
  assign sts.idx_last = idx == LAST_CPU;

endmodule

[sv/multi_cpu_set_assoc_tlb_lru_unit.sv]
// Lookup: one row read and one write-back, then the result is loaded once the output is free (read, update, output).
// Invalidate: one RAM read and one write-back per CPU row, then the result is loaded into the output.
// One item at a time; the tag RAM's single read port gives one row (all ways of one CPU's set) per read.
// Reset (sync, active high) starts a clear sweep over all NUM_CPUS*512 rows, one row per cycle,
// during which no item is accepted; afterwards all entries are invalid with ages in way order.
`include "multi_cpu_set_assoc_tlb_lru_unit_assert.svh"

module multi_cpu_set_assoc_tlb_lru_unit #(
  parameter int NUM_CPUS = 4
) (
  input  logic        clk,
  input  logic        rst,
  mtlb_req_if.sink    req,
  mtlb_rsp_if.source  rsp
);

  mtlb_pkg::cmd_t cmd;
  mtlb_pkg::sts_t sts;

  mtlb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .cmd      (cmd)
  );

  mtlb_dp #(
    .NUM_CPUS(NUM_CPUS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .mode   (req.mode),
    .cpu    (req.cpu),
    .page   (req.page),
    .hit    (rsp.hit),
    .cleared(rsp.cleared)
  );

  // No RAM traffic while an item can be taken
  `MTLB_ASSERT(a_idle_no_ram, clk, rst, req.ready |-> !(cmd.rd || cmd.upd || cmd.clr_wr))
  // Invalidate count bounded by the number of CPUs
  `MTLB_ASSERT(a_cleared_max, clk, rst, rsp.valid |-> (32'(rsp.cleared) <= 32'(NUM_CPUS)))
  // A lookup hit never carries a cleared count
  `MTLB_ASSERT(a_hit_no_clear, clk, rst, (rsp.valid && rsp.hit) |-> (rsp.cleared == '0))
  // Reset always enters the clear sweep
  `MTLB_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !req.ready)

endmodule

[tb/multi_cpu_set_assoc_tlb_lru_unit_test.sv]
`timescale 1ns / 100ps

import mtlb_pkg::*;

// Shadow copy of the per-CPU TLBs plus the queue of responses still owed by the DUT
class tlb_scoreboard #(int CPUS = 4);
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] cleared;
  } tlb_rsp_t;

  bit               way_valid [CPUS][NUM_SETS][NUM_WAYS];
  logic [TAG_W-1:0] way_tag   [CPUS][NUM_SETS][NUM_WAYS];
  logic [AGE_W-1:0] way_age   [CPUS][NUM_SETS][NUM_WAYS];
  tlb_rsp_t         owed_rsp[$];
  int               errors;

  // State right after the reset sweep: all invalid, ages in way order
  function new();
    errors = 0;
    for (int c = 0; c < CPUS; c++) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          way_valid[c][s][w] = 1'b0;
          way_tag[c][s][w]   = '0;
          way_age[c][s][w]   = AGE_W'(w);
        end
      end
    end
  endfunction

  // Make a way most recent; the ones newer than it get one step older
  function void touch_way(int c, int s, int w);
    logic [AGE_W-1:0] old_age;
    old_age = way_age[c][s][w];
    for (int v = 0; v < NUM_WAYS; v++) begin
      if (way_age[c][s][v] < old_age) way_age[c][s][v] = way_age[c][s][v] + 1'b1;
    end
    way_age[c][s][w] = '0;
  endfunction

  // Apply one accepted request to the shadow TLBs and queue the response it owes
  function void note_request(mode_t mode, logic [CPU_IN_W-1:0] cpu,
                             logic [PAGE_W-1:0] page);
    tlb_rsp_t         rsp;
    int               set_idx;
    logic [TAG_W-1:0] page_tag;
    int               victim;
    int               count;
    bit               found;
    rsp      = '0;
    set_idx  = int'(page[SET_BITS-1:0]);
    page_tag = page[PAGE_W-1:SET_BITS];
    if (mode == MODE_LOOKUP) begin
      if (int'(cpu) < CPUS) begin
        found = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (!found && way_valid[cpu][set_idx][w] && way_tag[cpu][set_idx][w] == page_tag) begin
            touch_way(int'(cpu), set_idx, w);
            rsp.hit = 1'b1;
            found   = 1'b1;
          end
        end
        // Miss: lowest invalid way, else the oldest one
        if (!found) begin
          victim = -1;
          for (int w = 0; w < NUM_WAYS; w++) begin
            if (victim < 0 && !way_valid[cpu][set_idx][w]) victim = w;
          end
          if (victim < 0) begin
            victim = 0;
            for (int w = 1; w < NUM_WAYS; w++) begin
              if (way_age[cpu][set_idx][w] > way_age[cpu][set_idx][victim]) victim = w;
            end
          end
          way_valid[cpu][set_idx][victim] = 1'b1;
          way_tag[cpu][set_idx][victim]   = page_tag;
          touch_way(int'(cpu), set_idx, victim);
        end
      end
    end else begin
      // Shootdown: first matching way per CPU, ages left alone
      count = 0;
      for (int c = 0; c < CPUS; c++) begin
        found = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (!found && way_valid[c][set_idx][w] && way_tag[c][set_idx][w] == page_tag) begin
            way_valid[c][set_idx][w] = 1'b0;
            found = 1'b1;
            count++;
          end
        end
      end
      rsp.cleared = (count > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(count);
    end
    owed_rsp.push_back(rsp);
  endfunction

  // Compare one accepted response beat with the oldest owed one
  function void check_response(logic hit, logic [CNT_W-1:0] cleared);
    tlb_rsp_t want;
    if (owed_rsp.size() == 0) begin
      $display("%0t: unexpected response beat hit=%0b cleared=%0d", $time, hit, cleared);
      errors++;
      return;
    end
    want = owed_rsp.pop_front();
    if (hit !== want.hit) begin
      $display("%0t: hit mismatch, expected %0b actual %0b", $time, want.hit, hit);
      errors++;
    end
    if (cleared !== want.cleared) begin
      $display("%0t: cleared mismatch, expected %0d actual %0d", $time, want.cleared, cleared);
      errors++;
    end
  endfunction
endclass

module multi_cpu_set_assoc_tlb_lru_unit_test;
  localparam int CPU_COUNT   = 4;
  localparam int RAND_ITEMS  = 650;
  localparam int HOT_SETS    = 4;
  localparam int HOT_TAGS    = 6;
  localparam int STALL_BEAT  = 60;
  localparam int STALL_LEN   = 300;
  localparam int CYCLE_LIMIT = 300000;

  logic clk;
  logic rst;
  int   cycles = 0;

  logic [SET_BITS-1:0] hot_set [HOT_SETS];
  logic [TAG_W-1:0]    hot_tag [HOT_SETS][HOT_TAGS];
  bit                  send_steady;

  tlb_scoreboard #(CPU_COUNT) sb;

  mtlb_req_if req_bus();
  mtlb_rsp_if rsp_bus();

  multi_cpu_set_assoc_tlb_lru_unit #(
    .NUM_CPUS(CPU_COUNT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  // Clock and reset
  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    sb  = new();
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Monitor: responses first, since a response never belongs to a same-edge request
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) sb.check_response(rsp_bus.hit, rsp_bus.cleared);
      if (req_bus.valid && req_bus.ready) sb.note_request(req_bus.mode, req_bus.cpu, req_bus.page);
    end
  end

  function automatic logic [PAGE_W-1:0] page_of(logic [TAG_W-1:0] tag, int set_idx);
    return {tag, SET_BITS'(set_idx)};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one request beat and hold it until the DUT takes it
  task automatic send_beat(mode_t mode, logic [CPU_IN_W-1:0] cpu, logic [PAGE_W-1:0] page);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.mode  <= mode;
    req_bus.cpu   <= cpu;
    req_bus.page  <= page;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
  endtask

  // New working set: a few sets, each with more tags than ways
  task automatic refresh_hot_pages();
    logic [63:0] r;
    for (int k = 0; k < HOT_SETS; k++) begin
      r = rand64();
      hot_set[k] = r[SET_BITS-1:0];
      for (int t = 0; t < HOT_TAGS; t++) begin
        r = rand64();
        hot_tag[k][t] = r[TAG_W-1:0];
      end
    end
  endtask

  // Mostly hot pages (hits, evictions, shootdowns), some random pages
  task automatic send_random();
    mode_t               mode;
    logic [CPU_IN_W-1:0] cpu;
    logic [PAGE_W-1:0]   page;
    logic [63:0]         r;
    int                  k;
    mode = ($urandom_range(0, 7) == 0) ? MODE_INVAL : MODE_LOOKUP;
    cpu  = CPU_IN_W'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 8) begin
      k    = $urandom_range(0, HOT_SETS - 1);
      page = {hot_tag[k][$urandom_range(0, HOT_TAGS - 1)], hot_set[k]};
    end else begin
      r    = rand64();
      page = r[PAGE_W-1:0];
    end
    send_beat(mode, cpu, page);
  endtask

  // Request side
  initial begin
    logic [PAGE_W-1:0] shared_page;
    req_bus.valid = 1'b0;
    req_bus.mode  = MODE_LOOKUP;
    req_bus.cpu   = '0;
    req_bus.page  = '0;
    send_steady   = 1'b0;
    @(negedge rst);
    @(posedge clk);

    // Extreme pages: miss then hit
    send_beat(MODE_LOOKUP, 2'd0, '0);
    send_beat(MODE_LOOKUP, 2'd0, '0);
    send_beat(MODE_LOOKUP, 2'd3, '1);
    send_beat(MODE_LOOKUP, 2'd3, '1);

    // Fill one set, then force LRU evictions
    for (int t = 1; t <= 4; t++) send_beat(MODE_LOOKUP, 2'd1, page_of(TAG_W'(t), 7));
    send_beat(MODE_LOOKUP, 2'd1, page_of(TAG_W'(1), 7));
    send_beat(MODE_LOOKUP, 2'd1, page_of(TAG_W'(5), 7));
    send_beat(MODE_LOOKUP, 2'd1, page_of(TAG_W'(2), 7));
    send_beat(MODE_LOOKUP, 2'd1, page_of(TAG_W'(1), 7));

    // Page held by every CPU: shootdown, repeat shootdown, refill into the freed way
    shared_page = page_of(TAG_W'({TAG_W{2'b10}}), 300);
    for (int c = 0; c < CPU_COUNT; c++) send_beat(MODE_LOOKUP, CPU_IN_W'(c), shared_page);
    send_beat(MODE_INVAL, 2'd2, shared_page);
    send_beat(MODE_INVAL, 2'd0, shared_page);
    send_beat(MODE_LOOKUP, 2'd2, shared_page);
    send_beat(MODE_INVAL, 2'd1, '0);
    send_beat(MODE_INVAL, 2'd3, '1);

    // Random traffic
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) refresh_hot_pages();
      if (i % 40 == 0) send_steady = ($urandom_range(0, 3) == 0);
      send_random();
    end
    req_bus.valid <= 1'b0;

    // Drain
    while (sb.owed_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Response side: random stalls, quiet stretches, one long hold-off to back up the DUT
  initial begin
    int beats;
    int gap;
    bit steady;
    rsp_bus.ready = 1'b0;
    beats  = 0;
    steady = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (beats % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if (beats == STALL_BEAT) gap = STALL_LEN;
      else gap = steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_bus.valid) @(posedge clk);
      beats++;
    end
  end
endmodule

[sim.f]
+incdir+sv
sv/mtlb_pkg.sv
sv/mtlb_if.sv
sv/mtlb_ram.sv
sv/mtlb_ctrl.sv
sv/mtlb_dp.sv
sv/multi_cpu_set_assoc_tlb_lru_unit.sv
tb/multi_cpu_set_assoc_tlb_lru_unit_test.sv
